### sv/lpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_pkg: shared types for the length-prefixed packet deframer
// Word formats, configuration fields, register indexes and parser states.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Input word: a received byte or a release of the pending packet
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       resync;
  } lpd_in_t;

  // Result word, one for every input word
  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        data_buffer;
    logic [8:0]  data_index;
    logic        packet_done;
    logic [9:0]  packet_length;
    logic [7:0]  packet_type;
    logic        overrun;
    logic        length_error;
    logic        pending_valid;
    logic [15:0] channel_count;
  } lpd_out_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] channel_type_code;
  } lpd_cfg_t;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_START_MARKER = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_TYPE = 1'b1;

  localparam logic [7:0] START_MARKER_RST = 8'h61;
  localparam logic [7:0] CHANNEL_TYPE_RST = 8'h01;

  localparam logic [9:0] LENGTH_SAT = 10'h3FF;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_LEN_HI  = 3'd1,
    ST_LEN_LO  = 3'd2,
    ST_TYPE    = 3'd3,
    ST_PAYLOAD = 3'd4
  } lpd_state_t;

endpackage
`default_nettype wire

### sv/lpd_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_in_reg: input register stage
// Holds one accepted word and hands it on when the next stage has room.
// ----------------------------------------------------------------------------
module lpd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lpd_pkg::lpd_in_t in_data,
  input  logic           pass_ok,
  output logic           step,
  output lpd_pkg::lpd_in_t item
);
  import lpd_pkg::*;

  logic    vld_r;
  lpd_in_t data_r;

  assign in_ready = !vld_r || pass_ok;
  assign step     = vld_r && pass_ok;
  assign item     = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

### sv/lpd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_parser: framing state machine and packet bookkeeping
// Works out the result word for the registered input word and updates the
// parse state, buffer, index, pending flag and channel counter on each step.
// ----------------------------------------------------------------------------
module lpd_parser #(
  parameter int unsigned PAYLOAD_DEPTH = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lpd_pkg::lpd_in_t  item,
  input  lpd_pkg::lpd_cfg_t cfg,
  output lpd_pkg::lpd_out_t result
);
  import lpd_pkg::*;

  localparam int unsigned IDX_W   = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [16:0] DEPTH_C = 17'(PAYLOAD_DEPTH);

  lpd_state_t        state_r, state_nxt, cur_state;
  logic              wb_r, wb_nxt, cur_wb;
  logic [15:0]       length_r, length_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt, cur_idx, idx_inc;
  logic              pend_r, pend_nxt;
  logic [15:0]       chan_r, chan_nxt;
  logic [15:0]       len_lo;
  logic              len_bad;
  logic              last;
  logic              dv, done, ovr, lerr;

  // Resync takes effect before the word itself is handled
  assign cur_state = item.resync ? ST_HUNT : state_r;
  assign cur_wb    = item.resync ? 1'b0 : wb_r;
  assign cur_idx   = item.resync ? '0 : idx_r;

  assign len_lo  = {length_r[15:8], item.rx_byte};
  assign len_bad = (len_lo == 16'h0000) || ({1'b0, len_lo} > DEPTH_C);
  assign idx_inc = cur_idx + 1'b1;
  assign last    = 16'(idx_inc) >= length_r;

  always_comb begin
    state_nxt = cur_state;
    if (!item.func) begin
      case (cur_state)
        ST_LEN_HI:  state_nxt = ST_LEN_LO;
        ST_LEN_LO:  state_nxt = len_bad ? ST_HUNT : ST_TYPE;
        ST_TYPE:    state_nxt = ST_PAYLOAD;
        ST_PAYLOAD: state_nxt = last ? ST_HUNT : ST_PAYLOAD;
        default:    state_nxt = (item.rx_byte == cfg.start_marker) ? ST_LEN_HI : ST_HUNT;
      endcase
    end
  end

  always_comb begin
    length_nxt = length_r;
    type_nxt   = type_r;
    idx_nxt    = cur_idx;
    wb_nxt     = cur_wb;
    pend_nxt   = item.func ? 1'b0 : pend_r;
    chan_nxt   = chan_r;
    dv         = 1'b0;
    done       = 1'b0;
    ovr        = 1'b0;
    lerr       = 1'b0;
    if (!item.func) begin
      case (cur_state)
        ST_LEN_HI: begin
          length_nxt = {item.rx_byte, 8'h00};
        end
        ST_LEN_LO: begin
          length_nxt = len_lo;
          lerr       = len_bad;
        end
        ST_TYPE: begin
          type_nxt = item.rx_byte;
          if (item.rx_byte == cfg.channel_type_code) begin
            chan_nxt = chan_r + 16'd1;
          end
        end
        ST_PAYLOAD: begin
          dv      = 1'b1;
          idx_nxt = last ? '0 : idx_inc;
          if (last) begin
            done     = 1'b1;
            ovr      = pend_r;
            pend_nxt = 1'b1;
            wb_nxt   = ~cur_wb;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.data_valid    = dv;
    result.data_byte     = dv ? item.rx_byte : 8'h00;
    result.data_buffer   = cur_wb;
    result.data_index    = dv ? 9'(cur_idx) : 9'd0;
    result.packet_done   = done;
    result.packet_length = (|length_nxt[15:10]) ? LENGTH_SAT : length_nxt[9:0];
    result.packet_type   = type_nxt;
    result.overrun       = ovr;
    result.length_error  = lerr;
    result.pending_valid = pend_nxt;
    result.channel_count = chan_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      wb_r     <= 1'b0;
      length_r <= '0;
      type_r   <= '0;
      idx_r    <= '0;
      pend_r   <= 1'b0;
      chan_r   <= '0;
    end else if (step) begin
      state_r  <= state_nxt;
      wb_r     <= wb_nxt;
      length_r <= length_nxt;
      type_r   <= type_nxt;
      idx_r    <= idx_nxt;
      pend_r   <= pend_nxt;
      chan_r   <= chan_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/length_prefixed_packet_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer: start marker / length / type deframer
// Splits a received byte stream into packets and tags each payload byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per received byte (func = 0) or per release of the
//           pending packet (func = 1); resync forces a return to hunting.
//   out_* : exactly one result word per input word, in order.
//   cfg_* : write-only registers (start marker, channel type code), to be
//           written while the block is idle; the block does not enforce it.
//   A word accepted into the input register is parsed out of it; its result
//   is held in the output register when the parser steps, which waits while
//   the output word is stalled. One word is accepted every cycle while the
//   receiver keeps up; the rate is set by the single pass through the parser.
//   Reset clears both registers' valid flags, the parser to hunting, buffer 0,
//   index 0, no packet pending and a zero channel count, and the
//   configuration registers to their defaults.
//   When the receiver stalls, the output word is held, the input register
//   still takes one more word, and in_ready drops only once both are full.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer #(
  parameter int unsigned PAYLOAD_DEPTH = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lpd_pkg::lpd_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lpd_pkg::lpd_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [lpd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [lpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lpd_pkg::*;

  lpd_cfg_t cfg_r;
  lpd_in_t  item;
  lpd_out_t result;
  lpd_out_t out_data_r;
  logic     out_valid_r;
  logic     pass_ok;
  logic     step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker      <= START_MARKER_RST;
      cfg_r.channel_type_code <= CHANNEL_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_MARKER: cfg_r.start_marker      <= cfg_wdata;
        REG_CHANNEL_TYPE: cfg_r.channel_type_code <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign pass_ok = !out_valid_r || out_ready;

  lpd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .pass_ok  (pass_ok),
    .step     (step),
    .item     (item)
  );

  lpd_parser #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // A full output register that is not being taken must block the parser.
  a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !step)
    else $error("parser stepped while the output word was stalled");

  // A completed packet always leaves a pending packet behind it.
  a_done_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.packet_done) |-> (out_data.data_valid && out_data.pending_valid))
    else $error("packet completion without a payload word or pending flag");

  // A dropped length never coincides with a payload word.
  a_lerr_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.length_error) |-> (!out_data.data_valid && !out_data.packet_done))
    else $error("length error reported together with payload");

  // Overrun is only flagged on the word that completes a packet.
  a_overrun_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overrun) |-> out_data.packet_done)
    else $error("overrun flagged without packet completion");
`endif

endmodule
`default_nettype wire

### tb/tb_length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_packet_deframer: self-checking bench for the deframer
// Drives received bytes and releases through a valid/ready channel, rebuilds
// every result word with an in-bench copy of the parser and compares each
// field. A short table of corner cases runs first, then randomised frames.
// ----------------------------------------------------------------------------
module tb_length_prefixed_packet_deframer;
  import lpd_pkg::*;

  localparam int unsigned PAYLOAD_DEPTH  = 512;
  localparam int          LATENCY        = 2;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    lpd_in_t  word;
    logic     fixed;
    lpd_out_t result;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  lpd_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  lpd_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Parser state as the bench expects it to be.
  lpd_state_t  parse_st     = ST_HUNT;
  logic        wr_buf       = 1'b0;
  logic [15:0] len_reg      = '0;
  logic [7:0]  type_reg     = '0;
  logic [15:0] byte_idx     = '0;
  logic        pending      = 1'b0;
  logic [15:0] chan_count   = '0;
  logic [7:0]  marker_cfg   = START_MARKER_RST;
  logic [7:0]  chan_code    = CHANNEL_TYPE_RST;

  lpd_out_t    expected_words[$];
  stim_row_t   dir_table[$];
  int unsigned words_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  bit          no_idle      = 1'b0;

  string field_names[11] = '{"data_valid", "data_byte", "data_buffer", "data_index",
                             "packet_done", "packet_length", "packet_type", "overrun",
                             "length_error", "pending_valid", "channel_count"};

  length_prefixed_packet_deframer #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic lpd_in_t in_word(input logic f, input logic [7:0] b, input logic rs);
    lpd_in_t w;
    w.func    = f;
    w.rx_byte = b;
    w.resync  = rs;
    return w;
  endfunction

  // Advances the expected parser state by one word and returns its result.
  function automatic lpd_out_t deframe_word(input lpd_in_t w);
    lpd_out_t r;
    r = '0;
    if (w.resync) begin
      parse_st = ST_HUNT;
      wr_buf   = 1'b0;
      byte_idx = '0;
    end
    r.data_buffer = wr_buf;
    if (w.func) begin
      pending = 1'b0;
    end else begin
      case (parse_st)
        ST_LEN_HI: begin
          len_reg  = {w.rx_byte, 8'h00};
          parse_st = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          len_reg = len_reg | {8'h00, w.rx_byte};
          if (len_reg == 0 || len_reg > PAYLOAD_DEPTH) begin
            r.length_error = 1'b1;
            parse_st       = ST_HUNT;
          end else begin
            parse_st = ST_TYPE;
          end
        end
        ST_TYPE: begin
          type_reg = w.rx_byte;
          if (w.rx_byte == chan_code) chan_count = chan_count + 16'd1;
          parse_st = ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          r.data_valid = 1'b1;
          r.data_byte  = w.rx_byte;
          r.data_index = byte_idx[8:0];
          byte_idx     = byte_idx + 16'd1;
          if (byte_idx >= len_reg) begin
            r.packet_done = 1'b1;
            r.overrun     = pending;
            pending       = 1'b1;
            wr_buf        = ~wr_buf;
            byte_idx      = '0;
            parse_st      = ST_HUNT;
          end
        end
        default: begin
          parse_st = (w.rx_byte == marker_cfg) ? ST_LEN_HI : ST_HUNT;
        end
      endcase
    end
    r.packet_length = (len_reg > 16'd1023) ? LENGTH_SAT : len_reg[9:0];
    r.packet_type   = type_reg;
    r.pending_valid = pending;
    r.channel_count = chan_count;
    return r;
  endfunction

  function automatic logic [15:0] field_of(input lpd_out_t w, input int i);
    case (i)
      0:       return 16'(w.data_valid);
      1:       return 16'(w.data_byte);
      2:       return 16'(w.data_buffer);
      3:       return 16'(w.data_index);
      4:       return 16'(w.packet_done);
      5:       return 16'(w.packet_length);
      6:       return 16'(w.packet_type);
      7:       return 16'(w.overrun);
      8:       return 16'(w.length_error);
      9:       return 16'(w.pending_valid);
      default: return w.channel_count;
    endcase
  endfunction

  function automatic stim_row_t row(input logic f, input logic [7:0] b, input logic rs);
    stim_row_t s;
    s        = '0;
    s.word   = in_word(f, b, rs);
    return s;
  endfunction

  function automatic stim_row_t row_known(input logic [7:0] b, input lpd_out_t r);
    stim_row_t s;
    s        = row(1'b0, b, 1'b0);
    s.fixed  = 1'b1;
    s.result = r;
    return s;
  endfunction

  // Result of a rejected length while no packet has been seen yet.
  function automatic lpd_out_t len_err_word(input logic [9:0] plen);
    lpd_out_t r;
    r               = '0;
    r.length_error  = 1'b1;
    r.packet_length = plen;
    return r;
  endfunction

  // Presents one word, holds it until taken, then queues what it should yield.
  // Valid is left high when no gap follows, so the next word follows at once.
  task automatic send_word(input lpd_in_t w, input logic fixed = 1'b0,
                           input lpd_out_t known = '0);
    lpd_out_t    pred;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pred = deframe_word(w);
    expected_words.push_back(fixed ? known : pred);
    words_sent++;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops the sender and lets the block drain completely.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == REG_START_MARKER) marker_cfg = value;
    else chan_code = value;
  endtask

  // Sends marker, length, type and payload, with a release slipped in at random
  // before some bytes. A bad length ends the frame after the length bytes. At
  // position cut the word carries resync and the frame is abandoned.
  task automatic send_frame(input logic [15:0] plen, input int cut);
    logic [7:0] frame[$];
    logic [7:0] ptype;
    frame = '{marker_cfg, plen[15:8], plen[7:0]};
    if (plen != 0 && plen <= PAYLOAD_DEPTH) begin
      ptype = ($urandom_range(0, 2) == 0) ? chan_code : 8'($urandom);
      frame.push_back(ptype);
      repeat (plen) frame.push_back(8'($urandom));
    end
    foreach (frame[k]) begin
      if (k == cut) begin
        send_word(in_word(1'($urandom), frame[k], 1'b1));
        return;
      end
      if ($urandom_range(0, 15) == 0) send_word(in_word(1'b1, 8'($urandom), 1'b0));
      send_word(in_word(1'b0, frame[k], 1'b0));
    end
  endtask

  task automatic run_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [15:0] plen;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      pick    = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 5) == 0);
      if (pick < 65) begin
        plen = ($urandom_range(0, 149) == 0) ? 16'($urandom_range(256, PAYLOAD_DEPTH))
                                             : 16'($urandom_range(1, 12));
        send_frame(plen, -1);
        if ($urandom_range(0, 1) == 0) send_word(in_word(1'b1, 8'($urandom), 1'b0));
      end else if (pick < 75) begin
        plen = ($urandom_range(0, 1) == 0) ? 16'h0000
                                           : 16'($urandom_range(PAYLOAD_DEPTH + 1, 65535));
        send_frame(plen, -1);
      end else if (pick < 83) begin
        plen = 16'($urandom_range(1, 12));
        send_frame(plen, $urandom_range(0, plen + 3));
      end else if (pick < 93) begin
        send_word(in_word($urandom_range(0, 3) == 0, 8'($urandom), $urandom_range(0, 7) == 0));
      end else begin
        send_word(in_word(1'b1, 8'($urandom), 1'($urandom)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stall before each word, then checks it field by field.
  initial begin
    lpd_out_t    exp_w;
    int unsigned gap;
    wait (rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        exp_w = expected_words.pop_front();
        for (int i = 0; i < 11; i++) begin
          if (field_of(out_data, i) !== field_of(exp_w, i)) begin
            $display("%0t: %s expected %0h got %0h", $time, field_names[i],
                     field_of(exp_w, i), field_of(out_data, i));
            mismatches++;
          end
        end
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** length_prefixed_packet_deframer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Corner cases with the reset configuration: zero and oversized lengths,
    // the byte after a bad length taken as a hunt byte, single-byte packets,
    // an overrun, resync together with release, release with nothing
    // pending, a saturated length and a resync in the middle of a header.
    dir_table = '{
      row_known(8'h00, '0),
      row_known(8'h61, '0),
      row_known(8'h00, '0),
      row_known(8'h00, len_err_word(10'd0)),
      row(1'b0, 8'h61, 1'b0),
      row(1'b0, 8'h02, 1'b0),
      row_known(8'h01, len_err_word(10'd513)),
      row(1'b0, 8'h61, 1'b0),
      row(1'b0, 8'h00, 1'b0),
      row(1'b0, 8'h01, 1'b0),
      row(1'b0, 8'h01, 1'b0),
      row(1'b0, 8'hFF, 1'b0),
      row(1'b0, 8'h61, 1'b0),
      row(1'b0, 8'h00, 1'b0),
      row(1'b0, 8'h01, 1'b0),
      row(1'b0, 8'hA5, 1'b0),
      row(1'b0, 8'h80, 1'b0),
      row(1'b1, 8'h5A, 1'b1),
      row(1'b1, 8'h00, 1'b0),
      row(1'b0, 8'h61, 1'b0),
      row(1'b0, 8'hFF, 1'b0),
      row(1'b0, 8'hFF, 1'b0),
      row(1'b0, 8'h61, 1'b0),
      row(1'b0, 8'h00, 1'b1)
    };
    foreach (dir_table[i]) send_word(dir_table[i].word, dir_table[i].fixed, dir_table[i].result);

    settle();
    write_reg(REG_START_MARKER, 8'h00);
    write_reg(REG_CHANNEL_TYPE, 8'h00);
    send_frame(16'(PAYLOAD_DEPTH), -1);
    run_traffic(330);

    settle();
    write_reg(REG_START_MARKER, 8'hFF);
    write_reg(REG_CHANNEL_TYPE, 8'hFF);
    run_traffic(330);

    settle();
    write_reg(REG_START_MARKER, 8'($urandom));
    write_reg(REG_CHANNEL_TYPE, 8'($urandom));
    run_traffic(165);
    // Hold the sender off until the block has delivered everything.
    settle();
    run_traffic(165);

    settle();
    write_reg(REG_CHANNEL_TYPE, 8'($urandom));
    write_reg(REG_START_MARKER, 8'($urandom));
    run_traffic(330);

    settle();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("** length_prefixed_packet_deframer: PASSED **");
    end else begin
      $display("** length_prefixed_packet_deframer: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
sv/lpd_pkg.sv
sv/lpd_in_reg.sv
sv/lpd_parser.sv
sv/length_prefixed_packet_deframer.sv
tb/tb_length_prefixed_packet_deframer.sv
